// ----- design/swsfr_pkg.sv -----
// ----------------------------------------------------------------------------
// swsfr_pkg
// Shared types and constants of the go-back-N sender with fast retransmit.
// ----------------------------------------------------------------------------
`default_nettype none

package swsfr_pkg;

    localparam int SEQ_BITS_DEF     = 4;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int KIND_W    = 2;
    localparam int PORT_SEQ_W = 4;
    localparam int PORT_PAY_W = 32;
    localparam int EXT_SEQ_W  = 8;
    localparam int EXT_PAY_W  = 64;
    localparam int DUP_W      = 4;

    localparam logic [DUP_W-1:0] DUP_MAX   = 4'd15;
    localparam logic [DUP_W-1:0] FAST_DUPS = 4'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_SEND    = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_TIMEOUT = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ACT_TX_NEW     = 3'd0,
        ACT_REFUSED    = 3'd1,
        ACT_RETX       = 3'd2,
        ACT_BAD_ACK    = 3'd3,
        ACT_ACK_OUTSIDE = 3'd4,
        ACT_ACK_OK     = 3'd5,
        ACT_EMPTY_TO   = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        TMR_NONE    = 2'd0,
        TMR_START   = 2'd1,
        TMR_STOP    = 2'd2,
        TMR_RESTART = 2'd3
    } timer_cmd_t;

endpackage

`default_nettype wire

// ----- design/swsfr_ram.sv -----
// ----------------------------------------------------------------------------
// swsfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module swsfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/swsfr_alu.sv -----
// ----------------------------------------------------------------------------
// swsfr_alu
// Shared sequence arithmetic: modular difference and increment.
// ----------------------------------------------------------------------------
`default_nettype none

module swsfr_alu #(
    parameter int SEQ_BITS = 4
) (
    input  wire logic [SEQ_BITS-1:0] a,
    input  wire logic [SEQ_BITS-1:0] b,
    output logic      [SEQ_BITS-1:0] diff,
    output logic      [SEQ_BITS-1:0] inc
);

    assign diff = a - b;
    assign inc  = a + SEQ_BITS'(1);

endmodule

`default_nettype wire

// ----- design/sliding_window_sender_fast_retransmit.sv -----
// ----------------------------------------------------------------------------
// sliding_window_sender_fast_retransmit
// Go-back-N sender with cumulative acks, fast retransmit on the third
// duplicate ack and full retransmission on timeout.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   command | start, busy         | kind, payload, ack_num, checksum_ok
//   result  | strobe              | action, seq_num, packet_data, timer_cmd,
//           |                     | last
//
// A send, a dropped ack or an empty timeout is decided in the evaluate state;
// an ack goes on to a window-check state. Each retransmitted packet takes a
// store read and then the beat; a timeout resends every outstanding packet
// and a fast retransmit resends only the oldest one.
// Reset clears the window and the duplicate-ack tracking; the store is not
// cleared. The receiver cannot stall; results are registered and appear in
// the cycle after they are decided.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_sender_fast_retransmit #(
    parameter int SEQ_BITS     = swsfr_pkg::SEQ_BITS_DEF,
    parameter int PAYLOAD_BITS = swsfr_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [swsfr_pkg::KIND_W-1:0]       kind,
    input  wire logic [swsfr_pkg::PORT_PAY_W-1:0]   payload,
    input  wire logic [swsfr_pkg::PORT_SEQ_W-1:0]   ack_num,
    input  wire logic                               checksum_ok,
    output logic                                    strobe,
    output logic [2:0]                              action,
    output logic [swsfr_pkg::PORT_SEQ_W-1:0]        seq_num,
    output logic [swsfr_pkg::PORT_PAY_W-1:0]        packet_data,
    output logic [1:0]                              timer_cmd,
    output logic                                    last
);

    import swsfr_pkg::*;

    localparam int WIN    = 2 ** (SEQ_BITS - 1);
    localparam int ADDR_W = $clog2(WIN);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_ACK,
        S_RD,
        S_RTX
    } state_t;

    state_t                  state_reg, state_next;
    kind_t                   kind_reg, kind_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic [SEQ_BITS-1:0]     ack_reg, ack_next;
    logic                    good_reg, good_next;

    logic [SEQ_BITS-1:0]     window_base_reg, window_base_next;
    logic [SEQ_BITS-1:0]     next_seq_reg, next_seq_next;
    logic [SEQ_BITS-1:0]     last_ack_reg, last_ack_next;
    logic                    last_ack_valid_reg, last_ack_valid_next;
    logic [DUP_W-1:0]        dup_count_reg, dup_count_next;
    logic [SEQ_BITS-1:0]     outst_reg, outst_next;
    logic [SEQ_BITS-1:0]     ptr_reg, ptr_next;
    logic                    first_reg, first_next;
    logic                    fast_reg, fast_next;

    logic                    strobe_reg, strobe_next;
    action_t                 action_reg, action_next;
    logic [PORT_SEQ_W-1:0]   seq_num_reg, seq_num_next;
    logic [PORT_PAY_W-1:0]   packet_data_reg, packet_data_next;
    timer_cmd_t              timer_cmd_reg, timer_cmd_next;
    logic                    last_reg, last_next;

    logic [SEQ_BITS-1:0]     alu_a, alu_b, alu_diff, alu_inc;

    logic                    ram_we, ram_re;
    logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
    logic [PAYLOAD_BITS-1:0] ram_rdata;

    logic [EXT_SEQ_W-1:0]    ack_ext, ptr_ext, nseq_ext;
    logic [EXT_PAY_W-1:0]    pay_in_ext, pay_reg_ext, rdata_ext;
    logic                    accept;

    assign accept      = start && (state_reg == S_IDLE);
    assign busy        = (state_reg != S_IDLE);
    assign ack_ext     = EXT_SEQ_W'(ack_num);
    assign ptr_ext     = EXT_SEQ_W'(ptr_reg);
    assign nseq_ext    = EXT_SEQ_W'(next_seq_reg);
    assign pay_in_ext  = EXT_PAY_W'(payload);
    assign pay_reg_ext = EXT_PAY_W'(pay_reg);
    assign rdata_ext   = EXT_PAY_W'(ram_rdata);

    swsfr_alu #(
        .SEQ_BITS (SEQ_BITS)
    ) u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .inc  (alu_inc)
    );

    swsfr_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (WIN)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pay_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        unique case (state_reg)
            S_ACK:
            begin
                alu_a = ack_reg;
                alu_b = window_base_reg;
            end
            S_RTX:
            begin
                alu_a = ptr_reg;
                alu_b = window_base_reg;
            end
            default:
            begin
                alu_a = next_seq_reg;
                alu_b = window_base_reg;
            end
        endcase
    end

    assign ram_waddr = next_seq_reg[ADDR_W-1:0];
    assign ram_raddr = ptr_reg[ADDR_W-1:0];
    assign ram_re    = (state_reg == S_RD);

    always_comb
    begin
        state_next          = state_reg;
        kind_next           = kind_reg;
        pay_next            = pay_reg;
        ack_next            = ack_reg;
        good_next           = good_reg;
        window_base_next    = window_base_reg;
        next_seq_next       = next_seq_reg;
        last_ack_next       = last_ack_reg;
        last_ack_valid_next = last_ack_valid_reg;
        dup_count_next      = dup_count_reg;
        outst_next          = outst_reg;
        ptr_next            = ptr_reg;
        first_next          = first_reg;
        fast_next           = fast_reg;
        strobe_next         = 1'b0;
        action_next         = action_reg;
        seq_num_next        = '0;
        packet_data_next    = '0;
        timer_cmd_next      = TMR_NONE;
        last_next           = 1'b1;
        ram_we              = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = kind_t'(kind);
                    pay_next   = PAYLOAD_BITS'(pay_in_ext);
                    ack_next   = SEQ_BITS'(ack_ext);
                    good_next  = checksum_ok;
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                state_next = S_IDLE;
                unique case (kind_reg)
                    KIND_SEND:
                    begin
                        strobe_next = 1'b1;
                        if (&alu_diff[SEQ_BITS-2:0])
                        begin
                            action_next = ACT_REFUSED;
                        end
                        else
                        begin
                            ram_we           = 1'b1;
                            action_next      = ACT_TX_NEW;
                            seq_num_next     = nseq_ext[PORT_SEQ_W-1:0];
                            packet_data_next = pay_reg_ext[PORT_PAY_W-1:0];
                            timer_cmd_next   = (alu_diff == '0) ? TMR_START : TMR_NONE;
                            next_seq_next    = alu_inc;
                        end
                    end
                    KIND_ACK:
                    begin
                        if (!good_reg)
                        begin
                            strobe_next = 1'b1;
                            action_next = ACT_BAD_ACK;
                        end
                        else
                        begin
                            if (!last_ack_valid_reg || (last_ack_reg != ack_reg))
                            begin
                                last_ack_next       = ack_reg;
                                last_ack_valid_next = 1'b1;
                                dup_count_next      = '0;
                            end
                            else if (dup_count_reg < DUP_MAX)
                            begin
                                dup_count_next = dup_count_reg + DUP_W'(1);
                            end
                            outst_next = alu_diff;
                            state_next = S_ACK;
                        end
                    end
                    KIND_TIMEOUT:
                    begin
                        if (alu_diff == '0)
                        begin
                            strobe_next    = 1'b1;
                            action_next    = ACT_EMPTY_TO;
                            timer_cmd_next = TMR_STOP;
                        end
                        else
                        begin
                            ptr_next   = window_base_reg;
                            first_next = 1'b1;
                            fast_next  = 1'b0;
                            state_next = S_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_ACK:
            begin
                state_next = S_IDLE;
                if (alu_diff >= outst_reg)
                begin
                    if (dup_count_reg == FAST_DUPS)
                    begin
                        dup_count_next = '0;
                        ptr_next       = window_base_reg;
                        first_next     = 1'b1;
                        fast_next      = 1'b1;
                        state_next     = S_RD;
                    end
                    else
                    begin
                        strobe_next = 1'b1;
                        action_next = ACT_ACK_OUTSIDE;
                    end
                end
                else
                begin
                    strobe_next      = 1'b1;
                    action_next      = ACT_ACK_OK;
                    window_base_next = alu_inc;
                    timer_cmd_next   = (alu_inc != next_seq_reg) ? TMR_RESTART : TMR_STOP;
                end
            end

            S_RD:
            begin
                state_next = S_RTX;
            end

            S_RTX:
            begin
                strobe_next      = 1'b1;
                action_next      = ACT_RETX;
                seq_num_next     = ptr_ext[PORT_SEQ_W-1:0];
                packet_data_next = rdata_ext[PORT_PAY_W-1:0];
                timer_cmd_next   = first_reg ? TMR_RESTART : TMR_NONE;
                last_next        = fast_reg || (alu_inc == next_seq_reg);
                first_next       = 1'b0;
                ptr_next         = alu_inc;
                state_next       = last_next ? S_IDLE : S_RD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            window_base_reg    <= '0;
            next_seq_reg       <= '0;
            last_ack_reg       <= '0;
            last_ack_valid_reg <= 1'b0;
            dup_count_reg      <= '0;
            strobe_reg         <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            window_base_reg    <= window_base_next;
            next_seq_reg       <= next_seq_next;
            last_ack_reg       <= last_ack_next;
            last_ack_valid_reg <= last_ack_valid_next;
            dup_count_reg      <= dup_count_next;
            strobe_reg         <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        pay_reg         <= pay_next;
        ack_reg         <= ack_next;
        good_reg        <= good_next;
        outst_reg       <= outst_next;
        ptr_reg         <= ptr_next;
        first_reg       <= first_next;
        fast_reg        <= fast_next;
        action_reg      <= action_next;
        seq_num_reg     <= seq_num_next;
        packet_data_reg <= packet_data_next;
        timer_cmd_reg   <= timer_cmd_next;
        last_reg        <= last_next;
    end

    assign strobe      = strobe_reg;
    assign action      = action_reg;
    assign seq_num     = seq_num_reg;
    assign packet_data = packet_data_reg;
    assign timer_cmd   = timer_cmd_reg;
    assign last        = last_reg;

    // A beat that is not the last of its command leaves the sequencer busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && !last_reg |-> state_reg != S_IDLE)
        else $error("non-final beat while idle");

    // The window never holds as many packets as the store has slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        SEQ_BITS'(next_seq_reg - window_base_reg) < SEQ_BITS'(WIN))
        else $error("window overflow");

    // Every retransmit beat follows a store read.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RTX |-> $past(state_reg) == S_RD)
        else $error("retransmit without store read");

    // An accepted command makes the block busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_EVAL)
        else $error("command not taken");

endmodule

`default_nettype wire

// ----- dv/sender_window_checker.sv -----
// ----------------------------------------------------------------------------
// sender_window_checker
// Watches the command and result channels of the go-back-N sender, predicts
// the result beats of every accepted command from its own copy of the window
// state and compares each result beat, field by field, with the oldest one
// still waiting.
// ----------------------------------------------------------------------------
module sender_window_checker
    import swsfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [KIND_W-1:0]     kind,
    input  logic [PORT_PAY_W-1:0] payload,
    input  logic [PORT_SEQ_W-1:0] ack_num,
    input  logic                  checksum_ok,
    input  logic                  strobe,
    input  logic [2:0]            action,
    input  logic [PORT_SEQ_W-1:0] seq_num,
    input  logic [PORT_PAY_W-1:0] packet_data,
    input  logic [1:0]            timer_cmd,
    input  logic                  last,
    output int                    fail_count,
    output int                    pending_beats,
    output int                    beats_checked
);

    typedef struct packed {
        action_t               act;
        logic [PORT_SEQ_W-1:0] seq;
        logic [PORT_PAY_W-1:0] data;
        timer_cmd_t            tmr;
        logic                  fin;
    } sender_beat_t;

    sender_beat_t          expected_beats[$];
    logic [PORT_SEQ_W-1:0] win_base;
    logic [PORT_SEQ_W-1:0] nxt_seq;
    logic [PORT_PAY_W-1:0] pkt_mem [0:7];
    logic [PORT_SEQ_W-1:0] prev_ack;
    logic                  prev_ack_seen;
    logic [DUP_W-1:0]      dup_cnt;
    int                    fails;
    int                    checked;

    function automatic sender_beat_t make_beat(action_t a, logic [PORT_SEQ_W-1:0] s,
                                               logic [PORT_PAY_W-1:0] d, timer_cmd_t t,
                                               logic f);
        sender_beat_t b;
        b.act  = a;
        b.seq  = s;
        b.data = d;
        b.tmr  = t;
        b.fin  = f;
        return b;
    endfunction

    task automatic predict_command(input kind_t k, input logic [PORT_PAY_W-1:0] pay,
                                   input logic [PORT_SEQ_W-1:0] ack, input logic ok);
        logic [PORT_SEQ_W-1:0] in_flight;
        logic [PORT_SEQ_W-1:0] ack_dist;
        logic [PORT_SEQ_W-1:0] idx;
        int                    n;
        case (k)
            KIND_SEND:
            begin
                if ((nxt_seq[2:0] + 3'd1) == win_base[2:0])
                begin
                    expected_beats.push_back(make_beat(ACT_REFUSED, '0, '0, TMR_NONE, 1'b1));
                end
                else
                begin
                    pkt_mem[nxt_seq[2:0]] = pay;
                    expected_beats.push_back(make_beat(ACT_TX_NEW, nxt_seq, pay,
                        (win_base == nxt_seq) ? TMR_START : TMR_NONE, 1'b1));
                    nxt_seq = nxt_seq + 4'd1;
                end
            end
            KIND_ACK:
            begin
                if (!ok)
                begin
                    expected_beats.push_back(make_beat(ACT_BAD_ACK, '0, '0, TMR_NONE, 1'b1));
                end
                else
                begin
                    if (!prev_ack_seen || prev_ack != ack)
                    begin
                        prev_ack      = ack;
                        prev_ack_seen = 1'b1;
                        dup_cnt       = '0;
                    end
                    else if (dup_cnt < DUP_MAX)
                    begin
                        dup_cnt = dup_cnt + 4'd1;
                    end
                    in_flight = nxt_seq - win_base;
                    ack_dist  = ack - win_base;
                    if (ack_dist >= in_flight)
                    begin
                        if (dup_cnt == FAST_DUPS)
                        begin
                            dup_cnt = '0;
                            expected_beats.push_back(make_beat(ACT_RETX, win_base,
                                pkt_mem[win_base[2:0]], TMR_RESTART, 1'b1));
                        end
                        else
                        begin
                            expected_beats.push_back(make_beat(ACT_ACK_OUTSIDE, '0, '0,
                                TMR_NONE, 1'b1));
                        end
                    end
                    else
                    begin
                        win_base = ack + 4'd1;
                        expected_beats.push_back(make_beat(ACT_ACK_OK, '0, '0,
                            (win_base != nxt_seq) ? TMR_RESTART : TMR_STOP, 1'b1));
                    end
                end
            end
            KIND_TIMEOUT:
            begin
                if (win_base == nxt_seq)
                begin
                    expected_beats.push_back(make_beat(ACT_EMPTY_TO, '0, '0, TMR_STOP, 1'b1));
                end
                else
                begin
                    idx = win_base;
                    n   = 0;
                    while (idx != nxt_seq)
                    begin
                        expected_beats.push_back(make_beat(ACT_RETX, idx, pkt_mem[idx[2:0]],
                            (n == 0) ? TMR_RESTART : TMR_NONE, (idx + 4'd1) == nxt_seq));
                        idx = idx + 4'd1;
                        n++;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic bit field_ok(string name, logic [PORT_PAY_W-1:0] want,
                                    logic [PORT_PAY_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic check_beat();
        sender_beat_t e;
        if (expected_beats.size() == 0)
        begin
            $error("Result beat with no command waiting: action %0d, seq_num %0d",
                   action, seq_num);
            fails++;
        end
        else
        begin
            e = expected_beats.pop_front();
            fails += !field_ok("action", e.act, action);
            fails += !field_ok("seq_num", e.seq, seq_num);
            fails += !field_ok("packet_data", e.data, packet_data);
            fails += !field_ok("timer_cmd", e.tmr, timer_cmd);
            fails += !field_ok("last", e.fin, last);
            checked++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_beats.delete();
            win_base      = '0;
            nxt_seq       = '0;
            prev_ack      = '0;
            prev_ack_seen = 1'b0;
            dup_cnt       = '0;
            fails         = 0;
            checked       = 0;
            fail_count    <= 0;
            pending_beats <= 0;
            beats_checked <= 0;
        end
        else
        begin
            if (strobe)
            begin
                check_beat();
            end
            if (start && !busy)
            begin
                predict_command(kind_t'(kind), payload, ack_num, checksum_ok);
            end
            fail_count    <= fails;
            pending_beats <= expected_beats.size();
            beats_checked <= checked;
        end
    end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives the go-back-N sender with directed window scenarios and then random
// sends, acks, duplicate-ack bursts and timeouts with random idle gaps, and
// gives the verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module tb_top;
    import swsfr_pkg::*;

    localparam int TOTAL_ITEMS = 260;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [KIND_W-1:0]     kind;
    logic [PORT_PAY_W-1:0] payload;
    logic [PORT_SEQ_W-1:0] ack_num;
    logic                  checksum_ok;
    logic                  strobe;
    logic [2:0]            action;
    logic [PORT_SEQ_W-1:0] seq_num;
    logic [PORT_PAY_W-1:0] packet_data;
    logic [1:0]            timer_cmd;
    logic                  last;
    int                    fail_count;
    int                    pending_beats;
    int                    beats_checked;
    int                    n_send;
    int                    n_ack;
    int                    n_timeout;
    int                    n_ignored;

    always #1 clk = ~clk;

    sliding_window_sender_fast_retransmit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .payload     (payload),
        .ack_num     (ack_num),
        .checksum_ok (checksum_ok),
        .strobe      (strobe),
        .action      (action),
        .seq_num     (seq_num),
        .packet_data (packet_data),
        .timer_cmd   (timer_cmd),
        .last        (last)
    );

    sender_window_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .payload       (payload),
        .ack_num       (ack_num),
        .checksum_ok   (checksum_ok),
        .strobe        (strobe),
        .action        (action),
        .seq_num       (seq_num),
        .packet_data   (packet_data),
        .timer_cmd     (timer_cmd),
        .last          (last),
        .fail_count    (fail_count),
        .pending_beats (pending_beats),
        .beats_checked (beats_checked)
    );

    task automatic send_cmd(input kind_t k, input logic [PORT_PAY_W-1:0] p,
                            input logic [PORT_SEQ_W-1:0] a, input logic ok);
        @(negedge clk);
        start       <= 1'b1;
        kind        <= k;
        payload     <= p;
        ack_num     <= a;
        checksum_ok <= ok;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        case (k)
            KIND_SEND:    n_send++;
            KIND_ACK:     n_ack++;
            KIND_TIMEOUT: n_timeout++;
            default:      n_ignored++;
        endcase
    endtask

    task automatic idle_gap(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        @(posedge clk);
        while (pending_beats != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        #200000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int                    sel;
        int                    burst;
        bit                    drained_mid;
        logic [PORT_SEQ_W-1:0] recent_ack;
        rst_n       = 1'b0;
        start       = 1'b0;
        kind        = KIND_SEND;
        payload     = '0;
        ack_num     = '0;
        checksum_ok = 1'b0;
        n_send      = 0;
        n_ack       = 0;
        n_timeout   = 0;
        n_ignored   = 0;
        drained_mid = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // The window is filled before any duplicate acks, so that a fast
        // retransmit never reads a slot of the store that was never written.
        send_cmd(KIND_TIMEOUT, '0, '0, 1'b0);
        send_cmd(KIND_NONE, $urandom, 4'hF, 1'b1);
        send_cmd(KIND_SEND, 32'h0000_0000, '0, 1'b0);
        send_cmd(KIND_SEND, 32'hFFFF_FFFF, 4'hF, 1'b1);
        idle_gap(2);
        send_cmd(KIND_SEND, 32'hA5A5_5A5A, '0, 1'b0);
        send_cmd(KIND_SEND, 32'h5A5A_A5A5, '0, 1'b0);
        send_cmd(KIND_SEND, $urandom, '0, 1'b0);
        send_cmd(KIND_SEND, $urandom, '0, 1'b0);
        send_cmd(KIND_SEND, $urandom, '0, 1'b0);
        send_cmd(KIND_SEND, $urandom, '0, 1'b0);
        send_cmd(KIND_ACK, '0, 4'hF, 1'b0);
        send_cmd(KIND_TIMEOUT, '0, '0, 1'b0);
        idle_gap(1);
        send_cmd(KIND_ACK, '0, 4'hF, 1'b1);
        send_cmd(KIND_ACK, '0, 4'h2, 1'b1);
        send_cmd(KIND_ACK, '0, 4'h6, 1'b1);
        send_cmd(KIND_SEND, $urandom, '0, 1'b0);
        send_cmd(KIND_SEND, $urandom, '0, 1'b0);
        send_cmd(KIND_ACK, '0, 4'h6, 1'b1);
        send_cmd(KIND_ACK, '0, 4'h6, 1'b1);
        idle_gap(3);
        send_cmd(KIND_ACK, '0, 4'h6, 1'b1);
        send_cmd(KIND_ACK, '0, 4'h7, 1'b1);
        send_cmd(KIND_ACK, '0, 4'h0, 1'b1);
        drain_results();

        recent_ack = '0;
        while (n_send + n_ack + n_timeout < TOTAL_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
            begin
                send_cmd(KIND_SEND, $urandom, PORT_SEQ_W'($urandom_range(0, 15)),
                         $urandom_range(0, 1) != 0);
            end
            else if (sel < 75)
            begin
                recent_ack = PORT_SEQ_W'($urandom_range(0, 15));
                send_cmd(KIND_ACK, $urandom, recent_ack, $urandom_range(0, 9) != 0);
            end
            else if (sel < 85)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    recent_ack = PORT_SEQ_W'($urandom_range(0, 15));
                end
                burst = $urandom_range(2, 17);
                repeat (burst)
                begin
                    send_cmd(KIND_ACK, $urandom, recent_ack, $urandom_range(0, 11) != 0);
                end
            end
            else if (sel < 97)
            begin
                send_cmd(KIND_TIMEOUT, $urandom, PORT_SEQ_W'($urandom_range(0, 15)),
                         $urandom_range(0, 1) != 0);
            end
            else
            begin
                send_cmd(KIND_NONE, $urandom, PORT_SEQ_W'($urandom_range(0, 15)),
                         $urandom_range(0, 1) != 0);
            end

            if (!drained_mid && n_send + n_ack + n_timeout >= TOTAL_ITEMS / 2)
            begin
                drained_mid = 1'b1;
                drain_results();
            end
            else if (n_send + n_ack + n_timeout < TOTAL_ITEMS - 40
                     && $urandom_range(0, 3) == 0)
            begin
                idle_gap($urandom_range(1, 3));
            end
        end

        drain_results();
        repeat (20) @(posedge clk);

        $display("Covered %0d commands: %0d sends, %0d acks, %0d timeouts, %0d ignored kinds.",
                 n_send + n_ack + n_timeout + n_ignored, n_send, n_ack, n_timeout, n_ignored);
        $display("Compared %0d result beats against the window predictor, %0d mismatches.",
                 beats_checked, fail_count);
        if (fail_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
